>>> rtl/lj_pair_force_min_image_core_macros.svh
// assertion macros for the lennard-jones pair force core
`ifndef LJ_PAIR_FORCE_MIN_IMAGE_CORE_MACROS_SVH
`define LJ_PAIR_FORCE_MIN_IMAGE_CORE_MACROS_SVH
`ifndef SYNTH
`define LPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpf check failed");
`define LPF_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lpf check failed");
`else
`define LPF_ASSERT_IMP(lbl, ante, cons)
`define LPF_ASSERT_NEVER(lbl, cond)
`endif
`endif

>>> rtl/lpf_pkg.sv
// shared types, constants and saturation helpers of the pair force core
`default_nettype none
package lpf_pkg;
  localparam int POS_FRAC_BITS = 24;
  localparam int INV_BITS = 30;
  localparam int POS_W = 32;
  localparam int S_W = 42;
  localparam int DIV_W = 56;
  localparam int CNT_W = $clog2(DIV_W);
  localparam int MUL_W = 64;
  localparam int PROD_W = 128;
  localparam int G_W = 39;
  localparam int TOT_W = 48;
  localparam int FRC_W = 32;
  localparam int ADDR_W = 4;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [S_W-1:0] CLAMP_Q =
    S_W'(((64'd9 << POS_FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [DIV_W-1:0] U_NUM = DIV_W'(1) << (INV_BITS + POS_FRAC_BITS);

  localparam int SH_SQ = POS_FRAC_BITS;
  localparam int SH_POW = INV_BITS;
  localparam int SH_FU = INV_BITS + POS_FRAC_BITS - 16;
  localparam int SH_VU = INV_BITS + POS_FRAC_BITS - 24;
  localparam int SH_K = POS_FRAC_BITS;
  localparam int SH_QM = INV_BITS + 32 - 16;
  localparam int SH_VD = POS_FRAC_BITS - 6;

  localparam logic [FRC_W-1:0] FRC_MAX = {1'b0, {(FRC_W-1){1'b1}}};
  localparam logic [FRC_W-1:0] FRC_MIN = {1'b1, {(FRC_W-1){1'b0}}};
  localparam logic [TOT_W-1:0] TOT_MAX = {1'b0, {(TOT_W-1){1'b1}}};
  localparam logic [TOT_W-1:0] TOT_MIN = {1'b1, {(TOT_W-1){1'b0}}};

  localparam logic [1:0] REG_BOX_X = 2'd0;
  localparam logic [1:0] REG_BOX_Y = 2'd1;
  localparam logic [1:0] REG_BOX_Z = 2'd2;

  typedef struct packed {
    logic                  new_step;
    logic [2:0]            rneg;
    logic [2:0][POS_W-1:0] rmag;
  } pair_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [S_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [FRC_W-1:0] sat_force(input logic neg,
                                                 input logic [PROD_W-1:0] mag);
    logic big_pos;
    logic big_neg;
    big_pos = |mag[PROD_W-1:FRC_W-1];
    big_neg = (|mag[PROD_W-1:FRC_W]) || (mag[FRC_W-1] && (|mag[FRC_W-2:0]));
    if (neg) begin
      sat_force = big_neg ? FRC_MIN : FRC_W'(0) - mag[FRC_W-1:0];
    end else begin
      sat_force = big_pos ? FRC_MAX : mag[FRC_W-1:0];
    end
  endfunction

  function automatic logic [TOT_W-1:0] sat_total(input logic neg,
                                                 input logic [PROD_W-1:0] mag);
    logic big_pos;
    logic big_neg;
    big_pos = |mag[PROD_W-1:TOT_W-1];
    big_neg = (|mag[PROD_W-1:TOT_W]) || (mag[TOT_W-1] && (|mag[TOT_W-2:0]));
    if (neg) begin
      sat_total = big_neg ? TOT_MIN : TOT_W'(0) - mag[TOT_W-1:0];
    end else begin
      sat_total = big_pos ? TOT_MAX : mag[TOT_W-1:0];
    end
  endfunction
endpackage
`default_nettype wire

>>> rtl/lj_pair_force_min_image_core.sv
// top level of the lennard-jones pair force core with minimum image
//
//   channel  direction  handshake          payload
//   in_      request    in_valid/in_stall  p1/p2 positions, new_step
//   out_     result     out_valid/out_stall forces, potential and virial totals
//   cfg      apb        psel/penable       box_x, box_y, box_z at 0x0, 0x4, 0x8
//
// the bit-serial divider runs one pass for a pair at or beyond the clamp, and five for
// a clamped pair that is not coincident; the multiplier sums four partial products.
// the queue takes two further requests while one is computed.
// rst_n is synchronous; sums clear to zero, box lengths to 1.0.
// a result waiting under out_stall holds; the next pair still computes up to its sums.
`default_nettype none
module lj_pair_force_min_image_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [lpf_pkg::POS_W-1:0]   in_p1_x,
  input  wire logic [lpf_pkg::POS_W-1:0]   in_p1_y,
  input  wire logic [lpf_pkg::POS_W-1:0]   in_p1_z,
  input  wire logic [lpf_pkg::POS_W-1:0]   in_p2_x,
  input  wire logic [lpf_pkg::POS_W-1:0]   in_p2_y,
  input  wire logic [lpf_pkg::POS_W-1:0]   in_p2_z,
  input  wire logic                        in_new_step,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [lpf_pkg::FRC_W-1:0] out_force_x,
  output logic signed [lpf_pkg::FRC_W-1:0] out_force_y,
  output logic signed [lpf_pkg::FRC_W-1:0] out_force_z,
  output logic signed [lpf_pkg::TOT_W-1:0] out_potential_total,
  output logic signed [lpf_pkg::TOT_W-1:0] out_virial_total,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lpf_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import lpf_pkg::*;

  logic [POS_W-1:0] box_x_r;
  logic [POS_W-1:0] box_y_r;
  logic [POS_W-1:0] box_z_r;
  logic             wr_en;
  logic [1:0]       reg_idx;

  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  pair_t    q_din;
  pair_t    q_head;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_BOX_X: prdata = box_x_r;
      REG_BOX_Y: prdata = box_y_r;
      REG_BOX_Z: prdata = box_z_r;
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r <= POS_W'(1) << POS_FRAC_BITS;
      box_y_r <= POS_W'(1) << POS_FRAC_BITS;
      box_z_r <= POS_W'(1) << POS_FRAC_BITS;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BOX_X: box_x_r <= pwdata;
        REG_BOX_Y: box_y_r <= pwdata;
        REG_BOX_Z: box_z_r <= pwdata;
        default: ;
      endcase
    end
  end

  lpf_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_p1_x     (in_p1_x),
    .in_p1_y     (in_p1_y),
    .in_p1_z     (in_p1_z),
    .in_p2_x     (in_p2_x),
    .in_p2_y     (in_p2_y),
    .in_p2_z     (in_p2_z),
    .in_new_step (in_new_step),
    .box_x       (box_x_r),
    .box_y       (box_y_r),
    .box_z       (box_z_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_din)
  );

  lpf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  lpf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  lpf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lpf_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .mul_req             (mul_req),
    .mul_rsp             (mul_rsp),
    .div_req             (div_req),
    .div_rsp             (div_rsp),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_force_x         (out_force_x),
    .out_force_y         (out_force_y),
    .out_force_z         (out_force_z),
    .out_potential_total (out_potential_total),
    .out_virial_total    (out_virial_total)
  );
endmodule
`default_nettype wire

>>> rtl/lpf_front.sv
// request intake: minimum-image separation per axis, pushed into the queue
`default_nettype none
module lpf_front (
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [lpf_pkg::POS_W-1:0] in_p1_x,
  input  wire logic [lpf_pkg::POS_W-1:0] in_p1_y,
  input  wire logic [lpf_pkg::POS_W-1:0] in_p1_z,
  input  wire logic [lpf_pkg::POS_W-1:0] in_p2_x,
  input  wire logic [lpf_pkg::POS_W-1:0] in_p2_y,
  input  wire logic [lpf_pkg::POS_W-1:0] in_p2_z,
  input  wire logic                      in_new_step,
  input  wire logic [lpf_pkg::POS_W-1:0] box_x,
  input  wire logic [lpf_pkg::POS_W-1:0] box_y,
  input  wire logic [lpf_pkg::POS_W-1:0] box_z,
  input  wire logic                      q_full,
  output logic                           q_push,
  output lpf_pkg::pair_t                 q_entry
);
  import lpf_pkg::*;

  logic [POS_W:0] ex;
  logic [POS_W:0] ey;
  logic [POS_W:0] ez;

  // returns {negative, magnitude}; ties keep the plain difference
  function automatic logic [POS_W:0] min_img(input logic [POS_W-1:0] a,
                                             input logic [POS_W-1:0] b,
                                             input logic [POS_W-1:0] len);
    logic signed [POS_W+2:0] d;
    logic signed [POS_W+2:0] dm;
    logic signed [POS_W+2:0] dp;
    logic [POS_W+2:0] a0;
    logic [POS_W+2:0] am;
    logic [POS_W+2:0] ap;
    d  = $signed({3'b000, a}) - $signed({3'b000, b});
    dm = d - $signed({3'b000, len});
    dp = d + $signed({3'b000, len});
    a0 = d[POS_W+2] ? -d : d;
    am = dm[POS_W+2] ? -dm : dm;
    ap = dp[POS_W+2] ? -dp : dp;
    if (am < a0 && am < ap) begin
      min_img = {dm[POS_W+2], am[POS_W-1:0]};
    end else if (ap < a0 && ap < am) begin
      min_img = {dp[POS_W+2], ap[POS_W-1:0]};
    end else begin
      min_img = {d[POS_W+2], a0[POS_W-1:0]};
    end
  endfunction

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    ex = min_img(in_p1_x, in_p2_x, box_x);
    ey = min_img(in_p1_y, in_p2_y, box_y);
    ez = min_img(in_p1_z, in_p2_z, box_z);
    q_entry.new_step = in_new_step;
    q_entry.rneg     = {ez[POS_W], ey[POS_W], ex[POS_W]};
    q_entry.rmag[0]  = ex[POS_W-1:0];
    q_entry.rmag[1]  = ey[POS_W-1:0];
    q_entry.rmag[2]  = ez[POS_W-1:0];
  end
endmodule
`default_nettype wire

>>> rtl/lpf_queue.sv
// short queue of classified pairs between intake and the compute sequencer
`default_nettype none
module lpf_queue (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  lpf_pkg::pair_t  din,
  input  wire logic       pop,
  output logic            full,
  output logic            empty,
  output lpf_pkg::pair_t  head
);
  import lpf_pkg::*;

  pair_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r;
  logic [QPTR_W-1:0] rd_r;
  logic [QPTR_W:0]   cnt_r;

  assign full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/lpf_mul.sv
// shared 64x64 multiplier built from four 32x32 partial products
`default_nettype none
module lpf_mul (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  lpf_pkg::mul_req_t  req,
  output lpf_pkg::mul_rsp_t  rsp
);
  import lpf_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [2:0]        step_r;
  logic [MUL_W-1:0]  a_r;
  logic [MUL_W-1:0]  b_r;
  logic [63:0]       pp_r;
  logic [1:0]        pp_idx_r;
  logic              pp_vld_r;
  logic [PROD_W-1:0] acc_r;
  logic [31:0]       ma;
  logic [31:0]       mb;
  logic [63:0]       pp_c;
  logic [PROD_W-1:0] pp_sh;

  assign ma   = step_r[1] ? a_r[63:32] : a_r[31:0];
  assign mb   = step_r[0] ? b_r[63:32] : b_r[31:0];
  assign pp_c = 64'(ma) * 64'(mb);

  always_comb begin
    case (pp_idx_r)
      2'd0:    pp_sh = {64'b0, pp_r};
      2'd3:    pp_sh = {pp_r, 64'b0};
      default: pp_sh = {32'b0, pp_r, 32'b0};
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r) begin
      pp_r     <= pp_c;
      pp_idx_r <= step_r[1:0];
      if (pp_vld_r) begin
        acc_r <= acc_r + pp_sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      step_r   <= '0;
      pp_vld_r <= 1'b0;
    end else begin
      done_r <= busy_r && (step_r == 3'd4);
      if (req.start) begin
        busy_r   <= 1'b1;
        step_r   <= '0;
        pp_vld_r <= 1'b0;
      end else if (busy_r) begin
        pp_vld_r <= (step_r != 3'd4);
        step_r   <= step_r + 1'b1;
        if (step_r == 3'd4) begin
          busy_r <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/lpf_div.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module lpf_div (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  lpf_pkg::div_req_t  req,
  output lpf_pkg::div_rsp_t  rsp
);
  import lpf_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] q_r;
  logic [S_W-1:0]   den_r;
  logic [S_W-1:0]   rem_r;
  logic [S_W:0]     trial;
  logic [S_W:0]     diff;
  logic             ge;

  assign trial = {rem_r, q_r[DIV_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[S_W-1:0] : trial[S_W-1:0];
      q_r   <= {q_r[DIV_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/lpf_back.sv
// compute sequencer: square sum, inverse powers, forces, running sums
`default_nettype none
`include "lj_pair_force_min_image_core_macros.svh"
module lpf_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      q_empty,
  input  lpf_pkg::pair_t                 q_head,
  output logic                           q_pop,
  output lpf_pkg::mul_req_t              mul_req,
  input  lpf_pkg::mul_rsp_t              mul_rsp,
  output lpf_pkg::div_req_t              div_req,
  input  lpf_pkg::div_rsp_t              div_rsp,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [lpf_pkg::FRC_W-1:0] out_force_x,
  output logic signed [lpf_pkg::FRC_W-1:0] out_force_y,
  output logic signed [lpf_pkg::FRC_W-1:0] out_force_z,
  output logic signed [lpf_pkg::TOT_W-1:0] out_potential_total,
  output logic signed [lpf_pkg::TOT_W-1:0] out_virial_total
);
  import lpf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_DIVU, ST_POW, ST_GSET, ST_FU, ST_VU,
    ST_KM, ST_KV, ST_QD, ST_QM, ST_VD, ST_SUM
  } state_t;

  state_t                state_r;
  logic                  op_r;
  logic [1:0]            ax_r;
  logic [2:0]            pw_idx_r;
  logic                  ns_r;
  logic [2:0]            rneg_r;
  logic [2:0][POS_W-1:0] rmag_r;
  logic [S_W-1:0]        s_r;
  logic [POS_W-1:0]      u_r;
  logic [4:0][POS_W-1:0] pw_r;
  logic                  gneg_r;
  logic [G_W-1:0]        gmag_r;
  logic [TOT_W-1:0]      pt_r;
  logic [G_W:0]          k_r;
  logic [G_W:0]          kv_r;
  logic [DIV_W-1:0]      q_r;
  logic [2:0][FRC_W-1:0] frc_r;
  logic [TOT_W-1:0]      vt_r;
  logic                  out_valid_r;
  logic [2:0][FRC_W-1:0] out_f_r;
  logic [TOT_W-1:0]      pot_r;
  logic [TOT_W-1:0]      vir_r;

  logic                    clamped;
  logic [S_W-1:0]          c_val;
  logic                    is_mul;
  logic                    is_div;
  logic                    mul_fin;
  logic                    div_fin;
  logic                    out_load;
  logic signed [POS_W+2:0] t_c;
  logic signed [G_W:0]     g_c;
  logic [G_W-1:0]          gmag_c;
  logic signed [POS_W:0]   pd_c;
  logic [POS_W:0]          pdm_c;
  logic [TOT_W-1:0]        pt_c;

  function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] acc,
                                               input logic [TOT_W-1:0] t);
    logic signed [TOT_W:0] v;
    v = $signed({acc[TOT_W-1], acc}) + $signed({t[TOT_W-1], t});
    if (v[TOT_W] != v[TOT_W-1]) begin
      sat_add = v[TOT_W] ? TOT_MIN : TOT_MAX;
    end else begin
      sat_add = v[TOT_W-1:0];
    end
  endfunction

  assign clamped  = s_r < CLAMP_Q;
  assign c_val    = clamped ? CLAMP_Q : s_r;
  assign mul_fin  = op_r && mul_rsp.done;
  assign div_fin  = op_r && div_rsp.done;
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign out_load = (state_r == ST_SUM) && (!out_valid_r || !out_stall);

  // g = 24*(2*u^7 - u^4), potential term = (u^6 - u^3)/16
  always_comb begin
    t_c    = $signed({2'b00, pw_r[4], 1'b0}) - $signed({3'b000, pw_r[2]});
    g_c    = ((G_W+1)'(t_c) <<< 4) + ((G_W+1)'(t_c) <<< 3);
    gmag_c = g_c[G_W] ? G_W'(-g_c) : G_W'(g_c);
    pd_c   = $signed({1'b0, pw_r[3]}) - $signed({1'b0, pw_r[1]});
    pdm_c  = pd_c[POS_W] ? -pd_c : pd_c;
    pt_c   = pd_c[POS_W] ? TOT_W'(0) - TOT_W'(pdm_c >> 4) : TOT_W'(pdm_c >> 4);
  end

  always_comb begin
    mul_req = '0;
    div_req = '0;
    is_mul  = 1'b0;
    is_div  = 1'b0;
    case (state_r)
      ST_SQ: begin
        is_mul    = 1'b1;
        mul_req.a = MUL_W'(rmag_r[ax_r]);
        mul_req.b = MUL_W'(rmag_r[ax_r]);
      end
      ST_DIVU: begin
        is_div      = 1'b1;
        div_req.num = U_NUM;
        div_req.den = c_val;
      end
      ST_POW: begin
        is_mul = 1'b1;
        case (pw_idx_r)
          3'd0: begin
            mul_req.a = MUL_W'(u_r);
            mul_req.b = MUL_W'(u_r);
          end
          3'd1: begin
            mul_req.a = MUL_W'(pw_r[0]);
            mul_req.b = MUL_W'(u_r);
          end
          3'd2: begin
            mul_req.a = MUL_W'(pw_r[0]);
            mul_req.b = MUL_W'(pw_r[0]);
          end
          3'd3: begin
            mul_req.a = MUL_W'(pw_r[1]);
            mul_req.b = MUL_W'(pw_r[1]);
          end
          default: begin
            mul_req.a = MUL_W'(pw_r[3]);
            mul_req.b = MUL_W'(u_r);
          end
        endcase
      end
      ST_FU: begin
        is_mul    = 1'b1;
        mul_req.a = MUL_W'(gmag_r);
        mul_req.b = MUL_W'(rmag_r[ax_r]);
      end
      ST_VU: begin
        is_mul    = 1'b1;
        mul_req.a = MUL_W'(gmag_r);
        mul_req.b = MUL_W'(s_r);
      end
      ST_KM: begin
        is_mul    = 1'b1;
        mul_req.a = MUL_W'(gmag_r);
        mul_req.b = MUL_W'(CLAMP_Q);
      end
      ST_KV: begin
        is_mul    = 1'b1;
        mul_req.a = MUL_W'(k_r);
        mul_req.b = MUL_W'(CLAMP_Q);
      end
      ST_QD: begin
        is_div      = 1'b1;
        div_req.num = DIV_W'({rmag_r[ax_r], 32'b0});
        div_req.den = s_r;
      end
      ST_QM: begin
        is_mul    = 1'b1;
        mul_req.a = MUL_W'(k_r);
        mul_req.b = MUL_W'(q_r);
      end
      ST_VD: begin
        is_div      = 1'b1;
        div_req.num = DIV_W'({kv_r, {SH_VD{1'b0}}});
        div_req.den = s_r;
      end
      default: ;
    endcase
    mul_req.start = is_mul && !op_r;
    div_req.start = is_div && !op_r;
  end

  assign out_valid           = out_valid_r;
  assign out_force_x         = out_f_r[0];
  assign out_force_y         = out_f_r[1];
  assign out_force_z         = out_f_r[2];
  assign out_potential_total = pot_r;
  assign out_virial_total    = vir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= 1'b0;
      ax_r        <= '0;
      pw_idx_r    <= '0;
      out_valid_r <= 1'b0;
      pot_r       <= '0;
      vir_r       <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (mul_req.start || div_req.start) begin
        op_r <= 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            ns_r    <= q_head.new_step;
            rneg_r  <= q_head.rneg;
            rmag_r  <= q_head.rmag;
            s_r     <= '0;
            ax_r    <= '0;
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (mul_fin) begin
            op_r <= 1'b0;
            s_r  <= s_r + S_W'(mul_rsp.prod >> SH_SQ);
            if (ax_r == 2'd2) begin
              state_r <= ST_DIVU;
            end else begin
              ax_r <= ax_r + 1'b1;
            end
          end
        end
        ST_DIVU: begin
          if (div_fin) begin
            op_r     <= 1'b0;
            u_r      <= POS_W'(div_rsp.quot);
            pw_idx_r <= '0;
            state_r  <= ST_POW;
          end
        end
        ST_POW: begin
          if (mul_fin) begin
            op_r             <= 1'b0;
            pw_r[pw_idx_r]   <= POS_W'(mul_rsp.prod >> SH_POW);
            if (pw_idx_r == 3'd4) begin
              state_r <= ST_GSET;
            end else begin
              pw_idx_r <= pw_idx_r + 1'b1;
            end
          end
        end
        ST_GSET: begin
          gneg_r <= g_c[G_W];
          gmag_r <= gmag_c;
          pt_r   <= pt_c;
          ax_r   <= '0;
          if (!clamped) begin
            state_r <= ST_FU;
          end else if (s_r == '0) begin
            // coincident particles: forces and virial term saturate
            frc_r[0] <= (g_c[G_W] ^ rneg_r[0]) ? FRC_MIN : FRC_MAX;
            frc_r[1] <= (g_c[G_W] ^ rneg_r[1]) ? FRC_MIN : FRC_MAX;
            frc_r[2] <= (g_c[G_W] ^ rneg_r[2]) ? FRC_MIN : FRC_MAX;
            vt_r     <= g_c[G_W] ? TOT_MIN : TOT_MAX;
            state_r  <= ST_SUM;
          end else begin
            state_r <= ST_KM;
          end
        end
        ST_FU: begin
          if (mul_fin) begin
            op_r        <= 1'b0;
            frc_r[ax_r] <= sat_force(gneg_r ^ rneg_r[ax_r], mul_rsp.prod >> SH_FU);
            if (ax_r == 2'd2) begin
              state_r <= ST_VU;
            end else begin
              ax_r <= ax_r + 1'b1;
            end
          end
        end
        ST_VU: begin
          if (mul_fin) begin
            op_r    <= 1'b0;
            vt_r    <= sat_total(gneg_r, mul_rsp.prod >> SH_VU);
            state_r <= ST_SUM;
          end
        end
        ST_KM: begin
          if (mul_fin) begin
            op_r    <= 1'b0;
            k_r     <= (G_W+1)'(mul_rsp.prod >> SH_K);
            state_r <= ST_KV;
          end
        end
        ST_KV: begin
          if (mul_fin) begin
            op_r    <= 1'b0;
            kv_r    <= (G_W+1)'(mul_rsp.prod >> SH_K);
            state_r <= ST_QD;
          end
        end
        ST_QD: begin
          if (div_fin) begin
            op_r    <= 1'b0;
            q_r     <= div_rsp.quot;
            state_r <= ST_QM;
          end
        end
        ST_QM: begin
          if (mul_fin) begin
            op_r        <= 1'b0;
            frc_r[ax_r] <= sat_force(gneg_r ^ rneg_r[ax_r], mul_rsp.prod >> SH_QM);
            if (ax_r == 2'd2) begin
              state_r <= ST_VD;
            end else begin
              ax_r    <= ax_r + 1'b1;
              state_r <= ST_QD;
            end
          end
        end
        ST_VD: begin
          if (div_fin) begin
            op_r    <= 1'b0;
            vt_r    <= sat_total(gneg_r, PROD_W'(div_rsp.quot));
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (out_load) begin
            out_f_r <= frc_r;
            pot_r   <= sat_add(ns_r ? TOT_W'(0) : pot_r, pt_r);
            vir_r   <= sat_add(ns_r ? TOT_W'(0) : vir_r, vt_r);
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `LPF_ASSERT_IMP(a_qd_clamped, state_r == ST_QD, (s_r != '0) && (s_r < CLAMP_Q))
  `LPF_ASSERT_IMP(a_fu_open, (state_r == ST_FU) || (state_r == ST_VU), s_r >= CLAMP_Q)
  `LPF_ASSERT_NEVER(a_units_overlap, mul_rsp.done && div_rsp.done)
  `LPF_ASSERT_IMP(a_idle_quiet, state_r == ST_IDLE, !mul_rsp.done && !div_rsp.done)
endmodule
`default_nettype wire
